[rtl/core/c8ie_pkg.sv]
package c8ie_pkg;

    // Fixed architecture sizes
    localparam int NUM_REGS = 16;
    localparam int MEM_SIZE = 4096;
    localparam int PC_W     = 12;
    localparam int REG_W    = 8;
    localparam int IDX_W    = 4;
    localparam int INS_W    = 16;
    localparam int OUT_W    = 40;

    localparam logic [PC_W-1:0]  C_RESET_PC = 12'h200;
    localparam logic [PC_W-1:0]  C_PC_STEP  = 12'd2;
    localparam logic [IDX_W-1:0] C_FLAG_REG = 4'hF;

    // Major opcode nibble
    localparam logic [3:0] C_OP_SYS  = 4'h0;
    localparam logic [3:0] C_OP_JP   = 4'h1;
    localparam logic [3:0] C_OP_CALL = 4'h2;
    localparam logic [3:0] C_OP_SE   = 4'h3;
    localparam logic [3:0] C_OP_SNE  = 4'h4;
    localparam logic [3:0] C_OP_SEXY = 4'h5;
    localparam logic [3:0] C_OP_LD   = 4'h6;
    localparam logic [3:0] C_OP_ADDI = 4'h7;
    localparam logic [3:0] C_OP_ALU  = 4'h8;

    // Register-register sub-op (low nibble of 8xyN)
    localparam logic [3:0] C_ALU_MOV = 4'h0;
    localparam logic [3:0] C_ALU_OR  = 4'h1;
    localparam logic [3:0] C_ALU_AND = 4'h2;
    localparam logic [3:0] C_ALU_XOR = 4'h3;
    localparam logic [3:0] C_ALU_ADD = 4'h4;

    // Whole-word system instructions
    localparam logic [INS_W-1:0] C_INS_CLS = 16'h00E0;
    localparam logic [INS_W-1:0] C_INS_RET = 16'h00EE;

    // Result beat, first member in the top bits
    typedef struct packed {
        logic [IDX_W-1:0] stack_pointer;
        logic             illegal_opcode;
        logic             skipped;
        logic             clear_display;
        logic             carry_flag;
        logic [REG_W-1:0] reg_write_value;
        logic [IDX_W-1:0] reg_write_index;
        logic             reg_write_enable;
        logic [PC_W-1:0]  next_pc;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load_ins;  // capture instruction, launch operand reads
        logic exec;      // commit instruction, capture result
        logic wr_vf;     // second write port cycle: carry into VF
        logic push_out;  // move result into output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_vf;   // add with carry into a register other than VF
    } t_dp_sts;

endpackage

[rtl/core/c8ie_ctrl.sv]
module c8ie_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output c8ie_pkg::t_dp_cmd  o_cmd,
    input  c8ie_pkg::t_dp_sts  i_sts
);
    import c8ie_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_VF,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   out_free;

    assign out_free = !r_m_tvalid || m_tready;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_tvalid;

    // Commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_ins = (r_state == S_IDLE) && s_tvalid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.wr_vf    = (r_state == S_VF);
        o_cmd.push_out = (r_state == S_OUT) && out_free;
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            // new result loaded, or the held one taken
            if ((r_state == S_OUT) && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_sts.need_vf ? S_VF : S_OUT;
                end
                S_VF: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/c8ie_datapath.sv]
module c8ie_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [c8ie_pkg::INS_W-1:0]       i_ins,
    input  logic                             i_cfg_wr_en,
    input  logic [c8ie_pkg::PC_W-1:0]        i_cfg_wr_data,
    input  c8ie_pkg::t_dp_cmd                i_cmd,
    output c8ie_pkg::t_dp_sts                o_sts,
    output logic [c8ie_pkg::OUT_W-1:0]       o_data
);
    import c8ie_pkg::*;

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);
    localparam int PAD_W = OUT_W - $bits(t_result);

    // Register file and return stack storage
    logic [REG_W-1:0] r_regs  [NUM_REGS];
    logic             r_reg_vld [NUM_REGS];
    logic [PC_W-1:0]  r_stack [STACK_DEPTH];
    logic             r_stk_vld [STACK_DEPTH];

    logic [INS_W-1:0] r_ins;
    logic [REG_W-1:0] r_vx_raw, r_vy_raw;
    logic             r_vx_ok, r_vy_ok;
    logic [PC_W-1:0]  r_stk_raw;
    logic             r_stk_ok;
    logic [PC_W-1:0]  r_pc;
    logic [SP_W-1:0]  r_sp;
    t_result          r_res;
    logic [OUT_W-1:0] r_out;

    // Instruction fields
    logic [3:0]       op, n;
    logic [IDX_W-1:0] x;
    logic [REG_W-1:0] kk;
    logic [PC_W-1:0]  nnn;
    logic [REG_W-1:0] vx, vy;
    logic [PC_W-1:0]  stk_top;
    logic [REG_W:0]   sum9;
    logic [PC_W-1:0]  pc_inc;
    logic [SP_W-1:0]  sp_inc, sp_dec;

    // Decode results
    logic             we, cls, skip, bad, carry, push, need_vf;
    logic [REG_W-1:0] wval;
    logic [PC_W-1:0]  n_pc;
    logic [SP_W-1:0]  n_sp;

    // Register file write port
    logic             rf_wr_en;
    logic [IDX_W-1:0] rf_wr_addr;
    logic [REG_W-1:0] rf_wr_data;

    assign op  = r_ins[15:12];
    assign x   = r_ins[11:8];
    assign n   = r_ins[3:0];
    assign kk  = r_ins[7:0];
    assign nnn = r_ins[11:0];

    assign vx      = r_vx_ok  ? r_vx_raw  : '0;
    assign vy      = r_vy_ok  ? r_vy_raw  : '0;
    assign stk_top = r_stk_ok ? r_stk_raw : '0;

    assign sum9   = {1'b0, vx} + {1'b0, vy};
    assign pc_inc = r_pc + C_PC_STEP;
    assign sp_inc = (r_sp == SP_LAST) ? '0 : r_sp + SP_W'(1);
    assign sp_dec = (r_sp == '0) ? SP_LAST : r_sp - SP_W'(1);

    // Instruction decode and execute
    always_comb begin
        we      = 1'b0;
        wval    = '0;
        carry   = 1'b0;
        cls     = 1'b0;
        skip    = 1'b0;
        bad     = 1'b0;
        push    = 1'b0;
        need_vf = 1'b0;
        n_pc    = pc_inc;
        n_sp    = r_sp;
        case (op)
            C_OP_SYS: begin
                if (r_ins == C_INS_CLS) begin
                    cls = 1'b1;
                end else if (r_ins == C_INS_RET) begin
                    n_pc = stk_top;
                    n_sp = sp_dec;
                end else begin
                    bad = 1'b1;
                end
            end
            C_OP_JP: begin
                n_pc = nnn;
            end
            C_OP_CALL: begin
                n_sp = sp_inc;
                push = 1'b1;
                n_pc = nnn;
            end
            C_OP_SE: begin
                skip = (vx == kk);
            end
            C_OP_SNE: begin
                skip = (vx != kk);
            end
            C_OP_SEXY: begin
                if (n != 4'h0) begin
                    bad = 1'b1;
                end else begin
                    skip = (vx == vy);
                end
            end
            C_OP_LD: begin
                we   = 1'b1;
                wval = kk;
            end
            C_OP_ADDI: begin
                we   = 1'b1;
                wval = vx + kk;
            end
            C_OP_ALU: begin
                case (n)
                    C_ALU_MOV: begin
                        we   = 1'b1;
                        wval = vy;
                    end
                    C_ALU_OR: begin
                        we   = 1'b1;
                        wval = vx | vy;
                    end
                    C_ALU_AND: begin
                        we   = 1'b1;
                        wval = vx & vy;
                    end
                    C_ALU_XOR: begin
                        we   = 1'b1;
                        wval = vx ^ vy;
                    end
                    C_ALU_ADD: begin
                        carry = sum9[REG_W];
                        we    = 1'b1;
                        // VF as destination ends up holding the carry
                        if (x == C_FLAG_REG) begin
                            wval = {{(REG_W-1){1'b0}}, carry};
                        end else begin
                            wval    = sum9[REG_W-1:0];
                            need_vf = 1'b1;
                        end
                    end
                    default: begin
                        bad = 1'b1;
                    end
                endcase
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (skip) begin
            n_pc = pc_inc + C_PC_STEP;
        end
    end

    assign o_sts.need_vf = need_vf;

    // Single write port: Vx on execute, VF on the follow-up cycle
    assign rf_wr_en   = (i_cmd.exec && we) || i_cmd.wr_vf;
    assign rf_wr_addr = i_cmd.wr_vf ? C_FLAG_REG : x;
    assign rf_wr_data = i_cmd.wr_vf ? {{(REG_W-1){1'b0}}, r_res.carry_flag} : wval;

    // Register file array
    always_ff @(posedge i_clk) begin
        if (rf_wr_en) begin
            r_regs[rf_wr_addr] <= rf_wr_data;
        end
        if (i_cmd.load_ins) begin
            r_vx_raw <= r_regs[i_ins[11:8]];
            r_vy_raw <= r_regs[i_ins[7:4]];
        end
    end

    // Return stack array
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push) begin
            r_stack[sp_inc] <= pc_inc;
        end
        if (i_cmd.load_ins) begin
            r_stk_raw <= r_stack[r_sp];
        end
    end

    // Valid bits, read qualifiers and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_reg_vld[i] <= 1'b0;
            end
            for (int i = 0; i < STACK_DEPTH; i++) begin
                r_stk_vld[i] <= 1'b0;
            end
            r_pc     <= C_RESET_PC;
            r_sp     <= '0;
            r_vx_ok  <= 1'b0;
            r_vy_ok  <= 1'b0;
            r_stk_ok <= 1'b0;
        end else begin
            if (rf_wr_en) begin
                r_reg_vld[rf_wr_addr] <= 1'b1;
            end
            if (i_cmd.exec && push) begin
                r_stk_vld[sp_inc] <= 1'b1;
            end
            if (i_cmd.load_ins) begin
                r_vx_ok  <= r_reg_vld[i_ins[11:8]];
                r_vy_ok  <= r_reg_vld[i_ins[7:4]];
                r_stk_ok <= r_stk_vld[r_sp];
            end
            if (i_cfg_wr_en) begin
                r_pc <= i_cfg_wr_data;
            end else if (i_cmd.exec) begin
                r_pc <= n_pc;
            end
            if (i_cmd.exec) begin
                r_sp <= n_sp;
            end
        end
    end

    // Instruction, result and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ins) begin
            r_ins <= i_ins;
        end
        if (i_cmd.exec) begin
            r_res.next_pc          <= n_pc;
            r_res.reg_write_enable <= we;
            r_res.reg_write_index  <= we ? x : '0;
            r_res.reg_write_value  <= we ? wval : '0;
            r_res.carry_flag       <= carry;
            r_res.clear_display    <= cls;
            r_res.skipped          <= skip;
            r_res.illegal_opcode   <= bad;
            r_res.stack_pointer    <= IDX_W'(n_sp);
        end
        if (i_cmd.push_out) begin
            r_out <= {{PAD_W{1'b0}}, r_res};
        end
    end

    assign o_data = r_out;

endmodule

[rtl/core/chip8_instruction_execute.sv]
// CHIP-8 instruction execute core. Each input beat is one 16-bit instruction word; each
// produces exactly one result beat with the new program counter, the general register
// write (if any), the VF carry, clear-screen, skip and illegal-opcode flags and the
// return stack pointer. An instruction's result is loaded into the output register after
// the execute state (and after the VF state for 8xy4 with x other than F, since the sum
// and the carry go through the register file's single write port one after the other);
// the next instruction is accepted on the cycle after that load, so the core takes no
// new instruction before the last result is loaded, and waits while the output
// register is still held by m_tready low. Writing the configuration register
// sets the start address and loads the program counter at once; reset loads 0x200.
// The register file and return stack clear through per-entry valid bits, so the core
// is ready right after reset.
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: start_address
    input  logic                        i_cfg_wr_en,
    input  logic [c8ie_pkg::PC_W-1:0]   i_cfg_wr_data,
    // Instruction stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [c8ie_pkg::INS_W-1:0]  s_tdata,   // [15:0] instruction_word
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [11:0] next_pc, [12] reg_write_enable, [16:13] reg_write_index,
    // [24:17] reg_write_value, [25] carry_flag, [26] clear_display,
    // [27] skipped, [28] illegal_opcode, [32:29] stack_pointer, [39:33] zero
    output logic [c8ie_pkg::OUT_W-1:0]  m_tdata
);
    import c8ie_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    c8ie_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    c8ie_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ins         (s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_data        (m_tdata)
    );

endmodule
